### src/rwiu_pkg.sv
`default_nettype none

package rwiu_pkg;

  // field and datapath widths
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned FRM_W     = 32;
  localparam int unsigned FSZ_W     = 15;
  localparam int unsigned RING_W    = 17;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned TOT_W     = 64;
  localparam int unsigned PROD_W    = 47;
  localparam int unsigned NUM_W     = 48;
  localparam int unsigned ERR_W     = 18;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STS_W     = 2;

  localparam logic [RING_W-1:0] RING_RESET = RING_W'(1024);
  localparam logic [RING_W-1:0] RING_MIN   = RING_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RING_SIZE,
    REG_START_INDEX,
    REG_START_FRAMES,
    REG_FRAME_SIZE
  } reg_idx_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK,
    STS_CFG_INVALID,
    STS_INDEX_RANGE,
    STS_FRAME_LARGE
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_ACC,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

### src/rwiu_ser_mul.sv
`default_nettype none

// shift-add multiplier, one multiplier bit per cycle
module rwiu_ser_mul (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [rwiu_pkg::FRM_W-1:0]     multiplier_i,
  input  wire logic [rwiu_pkg::FSZ_W-1:0]     multiplicand_i,
  output logic                                done_o,
  output logic [rwiu_pkg::PROD_W-1:0]         product_o
);

  localparam int unsigned HI_W  = rwiu_pkg::NUM_W - rwiu_pkg::FRM_W;
  localparam int unsigned CNT_W = $clog2(rwiu_pkg::FRM_W);

  logic [rwiu_pkg::NUM_W-1:0] prod_q, prod_d;
  logic [rwiu_pkg::FSZ_W-1:0] mcand_q, mcand_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [HI_W:0]              sum;

  always_comb begin
    sum = {1'b0, prod_q[rwiu_pkg::NUM_W-1:rwiu_pkg::FRM_W]}
        + (prod_q[0] ? (HI_W+1)'(mcand_q) : '0);
  end

  always_comb begin
    prod_d  = prod_q;
    mcand_d = mcand_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      prod_d  = {{HI_W{1'b0}}, multiplier_i};
      mcand_d = multiplicand_i;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      prod_d = {sum, prod_q[rwiu_pkg::FRM_W-1:1]};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    mcand_q <= mcand_d;
  end

  assign done_o    = done_q;
  assign product_o = prod_q[rwiu_pkg::PROD_W-1:0];

endmodule

`default_nettype wire

### src/rwiu_ser_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle; keeps remainder and a nonzero flag
module rwiu_ser_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [rwiu_pkg::NUM_W-1:0]     dividend_i,
  input  wire logic [rwiu_pkg::RING_W-1:0]    divisor_i,
  output logic                                done_o,
  output logic [rwiu_pkg::RING_W-1:0]         rem_o,
  output logic                                quot_nz_o
);

  localparam int unsigned CNT_W = $clog2(rwiu_pkg::NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rwiu_pkg::NUM_W - 1);

  logic [rwiu_pkg::NUM_W-1:0]  num_q, num_d;
  logic [rwiu_pkg::RING_W-1:0] rem_q, rem_d;
  logic [rwiu_pkg::RING_W-1:0] dvs_q, dvs_d;
  logic                        nz_q, nz_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [rwiu_pkg::RING_W:0]   trial;
  logic [rwiu_pkg::RING_W:0]   diff;

  always_comb begin
    trial = {rem_q, num_q[rwiu_pkg::NUM_W-1]};
    diff  = trial - {1'b0, dvs_q};
  end

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    nz_d   = nz_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      nz_d   = 1'b0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[rwiu_pkg::NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[rwiu_pkg::RING_W-1:0];
        nz_d  = 1'b1;
      end else begin
        rem_d = trial[rwiu_pkg::RING_W-1:0];
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    nz_q  <= nz_d;
  end

  assign done_o    = done_q;
  assign rem_o     = rem_q;
  assign quot_nz_o = nz_q;

endmodule

`default_nettype wire

### src/rwiu_ser_acc.sv
`default_nettype none

// running word total, updated by a bit-serial adder as the total register rotates
module rwiu_ser_acc (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           clear_i,
  input  wire logic                           start_i,
  input  wire logic [rwiu_pkg::NUM_W-1:0]     addend_i,
  output logic                                done_o,
  output logic [rwiu_pkg::TOT_W-1:0]          total_o
);

  localparam int unsigned CNT_W = $clog2(rwiu_pkg::TOT_W);

  logic [rwiu_pkg::TOT_W-1:0] tot_q, tot_d;
  logic [rwiu_pkg::NUM_W-1:0] add_q, add_d;
  logic                       carry_q, carry_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic                       a, b;

  always_comb begin
    a       = tot_q[0];
    b       = add_q[0];
    tot_d   = tot_q;
    add_d   = add_q;
    carry_d = carry_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (clear_i) begin
      tot_d  = '0;
      busy_d = 1'b0;
    end else if (start_i) begin
      add_d   = addend_i;
      carry_d = 1'b0;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      tot_d   = {a ^ b ^ carry_q, tot_q[rwiu_pkg::TOT_W-1:1]};
      carry_d = (a & b) | (a & carry_q) | (b & carry_q);
      add_d   = {1'b0, add_q[rwiu_pkg::NUM_W-1:1]};
      cnt_d   = cnt_q + CNT_W'(1);
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      tot_q  <= tot_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    add_q   <= add_d;
    carry_q <= carry_d;
  end

  assign done_o  = done_q;
  assign total_o = tot_q;

endmodule

`default_nettype wire

### src/ring_write_index_unwrapper.sv
`default_nettype none

// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o  | write_index_i, frame_count_i
// out     | output    | out_valid_o/out_stall_i| total_words_o, status_o
// cfg     | input     | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// one observation at a time; a rejected observation goes from idle straight to the output state
// with no frame size: idle, finish, the bit-serial total update, then the output state
// with frame size: 32 multiplier steps and prepare first; the 48 divider steps run only on a shortfall
// reset clears the total and loads last index/frame count from the start registers
// the output register holds a finished transfer while out_stall_i is high; the next
// observation is taken as soon as the result has moved into that register
module ring_write_index_unwrapper #(
  parameter int unsigned MAX_RING_WORDS = 65536
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [rwiu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rwiu_pkg::CFG_W-1:0]      cfg_wdata_i,
  // observations
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [rwiu_pkg::IDX_W-1:0]      write_index_i,
  input  wire logic [rwiu_pkg::FRM_W-1:0]      frame_count_i,
  // results
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [rwiu_pkg::TOT_W-1:0]           total_words_o,
  output logic [rwiu_pkg::STS_W-1:0]           status_o
);

  localparam logic [31:0] MAX_RING = 32'(MAX_RING_WORDS);

  // configuration registers
  logic [rwiu_pkg::RING_W-1:0] ring_q, ring_d;
  logic [rwiu_pkg::IDX_W-1:0]  start_idx_q, start_idx_d;
  logic [rwiu_pkg::FRM_W-1:0]  start_frm_q, start_frm_d;
  logic [rwiu_pkg::FSZ_W-1:0]  fsz_q, fsz_d;
  logic                        restart;

  // tracking state
  logic [rwiu_pkg::IDX_W-1:0]  last_idx_q, last_idx_d;
  logic [rwiu_pkg::FRM_W-1:0]  last_frm_q, last_frm_d;

  // per-observation working registers
  rwiu_pkg::state_e            state_q, state_d;
  rwiu_pkg::status_e           status_q, status_d;
  rwiu_pkg::status_e           sts_c;
  logic [rwiu_pkg::RING_W-1:0] mod_delta_q, mod_delta_d;
  logic                        lift_en_q, lift_en_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [rwiu_pkg::TOT_W-1:0]  total_q;
  logic [rwiu_pkg::STS_W-1:0]  status_out_q;

  // unit handshakes
  logic                        in_accept;
  logic                        out_free;
  logic                        mul_start, div_start, acc_start, out_load;
  logic                        mul_done, div_done, acc_done;
  logic [rwiu_pkg::PROD_W-1:0] product;
  logic [rwiu_pkg::RING_W-1:0] div_rem;
  logic                        div_nz;
  logic [rwiu_pkg::TOT_W-1:0]  acc_total;

  // derived values
  logic                        cfg_ok;
  logic [rwiu_pkg::RING_W-1:0] mod_delta_c;
  logic [rwiu_pkg::HALF_W-1:0] half;
  logic                        exp_gt;
  logic [rwiu_pkg::NUM_W-1:0]  dividend;
  logic [rwiu_pkg::ERR_W-1:0]  rnd_diff;
  logic [rwiu_pkg::ERR_W-1:0]  rnd_err;
  logic                        lift;
  logic [rwiu_pkg::NUM_W-1:0]  observed;

  // ---------------------------------------------------------------------------
  // configuration port; writes to the ring size or either start register
  // restart tracking from the (new) start values
  // ---------------------------------------------------------------------------
  always_comb begin
    ring_d      = ring_q;
    start_idx_d = start_idx_q;
    start_frm_d = start_frm_q;
    fsz_d       = fsz_q;
    restart     = 1'b0;
    if (cfg_we_i) begin
      unique case (rwiu_pkg::reg_idx_e'(cfg_index_i))
        rwiu_pkg::REG_RING_SIZE: begin
          ring_d  = cfg_wdata_i[rwiu_pkg::RING_W-1:0];
          restart = 1'b1;
        end
        rwiu_pkg::REG_START_INDEX: begin
          start_idx_d = cfg_wdata_i[rwiu_pkg::IDX_W-1:0];
          restart     = 1'b1;
        end
        rwiu_pkg::REG_START_FRAMES: begin
          start_frm_d = cfg_wdata_i[rwiu_pkg::FRM_W-1:0];
          restart     = 1'b1;
        end
        rwiu_pkg::REG_FRAME_SIZE: begin
          fsz_d = cfg_wdata_i[rwiu_pkg::FSZ_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // checks on the incoming observation, in order of precedence
  // ---------------------------------------------------------------------------
  always_comb begin
    cfg_ok = (ring_q >= rwiu_pkg::RING_MIN) && (32'(ring_q) <= MAX_RING)
          && ({1'b0, start_idx_q} < ring_q);
    if (!cfg_ok) begin
      sts_c = rwiu_pkg::STS_CFG_INVALID;
    end else if ({1'b0, write_index_i} >= ring_q) begin
      sts_c = rwiu_pkg::STS_INDEX_RANGE;
    end else if ((fsz_q != '0) && ({1'b0, fsz_q, 1'b0} >= ring_q)) begin
      sts_c = rwiu_pkg::STS_FRAME_LARGE;
    end else begin
      sts_c = rwiu_pkg::STS_OK;
    end
  end

  // modular advance of the write index around the ring
  always_comb begin
    if (write_index_i >= last_idx_q) begin
      mod_delta_c = {1'b0, write_index_i - last_idx_q};
    end else begin
      mod_delta_c = ring_q - {1'b0, last_idx_q} + {1'b0, write_index_i};
    end
  end

  assign half = ring_q[rwiu_pkg::RING_W-1:1];

  // expected advance above the modular one: numerator for the rounded ring count
  always_comb begin
    exp_gt   = product > rwiu_pkg::PROD_W'(mod_delta_q);
    dividend = {1'b0, product} + rwiu_pkg::NUM_W'(half)
             - rwiu_pkg::NUM_W'(mod_delta_q);
  end

  // lifted minus expected equals half a ring less the division remainder,
  // so the lift check and the lifted value need no second multiplication
  always_comb begin
    rnd_diff = rwiu_pkg::ERR_W'(half) - rwiu_pkg::ERR_W'(div_rem);
    rnd_err  = rnd_diff[rwiu_pkg::ERR_W-1] ? (~rnd_diff + rwiu_pkg::ERR_W'(1)) : rnd_diff;
    lift     = lift_en_q && div_nz && (rnd_err <= rwiu_pkg::ERR_W'(fsz_q));
    if (lift) begin
      observed = {1'b0, product}
               + {{(rwiu_pkg::NUM_W-rwiu_pkg::ERR_W){rnd_diff[rwiu_pkg::ERR_W-1]}},
                  rnd_diff};
    end else begin
      observed = rwiu_pkg::NUM_W'(mod_delta_q);
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rwiu_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_c != rwiu_pkg::STS_OK) begin
            state_d = rwiu_pkg::ST_OUT;
          end else if (fsz_q == '0) begin
            state_d = rwiu_pkg::ST_FIN;
          end else begin
            state_d = rwiu_pkg::ST_MUL;
          end
        end
      end
      rwiu_pkg::ST_MUL: begin
        if (mul_done) begin
          state_d = rwiu_pkg::ST_PREP;
        end
      end
      rwiu_pkg::ST_PREP: begin
        state_d = exp_gt ? rwiu_pkg::ST_DIV : rwiu_pkg::ST_FIN;
      end
      rwiu_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = rwiu_pkg::ST_FIN;
        end
      end
      rwiu_pkg::ST_FIN: begin
        state_d = rwiu_pkg::ST_ACC;
      end
      rwiu_pkg::ST_ACC: begin
        if (acc_done) begin
          state_d = rwiu_pkg::ST_OUT;
        end
      end
      rwiu_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = rwiu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rwiu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    acc_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      rwiu_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        mul_start  = in_valid_i && (sts_c == rwiu_pkg::STS_OK) && (fsz_q != '0);
      end
      rwiu_pkg::ST_MUL: begin
      end
      rwiu_pkg::ST_PREP: begin
        div_start = exp_gt;
      end
      rwiu_pkg::ST_DIV: begin
      end
      rwiu_pkg::ST_FIN: begin
        acc_start = 1'b1;
      end
      rwiu_pkg::ST_ACC: begin
      end
      rwiu_pkg::ST_OUT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // working and tracking registers
  always_comb begin
    status_d    = status_q;
    mod_delta_d = mod_delta_q;
    lift_en_d   = lift_en_q;
    last_idx_d  = last_idx_q;
    last_frm_d  = last_frm_q;
    if (restart) begin
      last_idx_d = start_idx_d;
      last_frm_d = start_frm_d;
    end else if (in_accept) begin
      status_d  = sts_c;
      lift_en_d = 1'b0;
      if (sts_c == rwiu_pkg::STS_OK) begin
        // a rejected observation leaves the tracking state alone
        mod_delta_d = mod_delta_c;
        last_idx_d  = write_index_i;
        last_frm_d  = frame_count_i;
      end
    end else if (state_q == rwiu_pkg::ST_PREP) begin
      lift_en_d = exp_gt;
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q      <= rwiu_pkg::RING_RESET;
      start_idx_q <= '0;
      start_frm_q <= '0;
      fsz_q       <= '0;
      last_idx_q  <= '0;
      last_frm_q  <= '0;
      state_q     <= rwiu_pkg::ST_IDLE;
      status_q    <= rwiu_pkg::STS_OK;
      lift_en_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ring_q      <= ring_d;
      start_idx_q <= start_idx_d;
      start_frm_q <= start_frm_d;
      fsz_q       <= fsz_d;
      last_idx_q  <= last_idx_d;
      last_frm_q  <= last_frm_d;
      state_q     <= state_d;
      status_q    <= status_d;
      lift_en_q   <= lift_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_delta_q <= mod_delta_d;
    if (out_load) begin
      total_q      <= acc_total;
      status_out_q <= status_q;
    end
  end

  // ---------------------------------------------------------------------------
  // serial units
  // ---------------------------------------------------------------------------
  rwiu_ser_mul u_mul (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (mul_start),
    .multiplier_i   (frame_count_i - last_frm_q),
    .multiplicand_i (fsz_q),
    .done_o         (mul_done),
    .product_o      (product)
  );

  rwiu_ser_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (ring_q),
    .done_o     (div_done),
    .rem_o      (div_rem),
    .quot_nz_o  (div_nz)
  );

  rwiu_ser_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (restart),
    .start_i  (acc_start),
    .addend_i (observed),
    .done_o   (acc_done),
    .total_o  (acc_total)
  );

  assign out_valid_o   = out_valid_q;
  assign total_words_o = total_q;
  assign status_o      = status_out_q;

`ifndef NO_ASSERTIONS
  // the total is only updated for an accepted observation
  a_acc_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rwiu_pkg::ST_ACC) |-> (status_q == rwiu_pkg::STS_OK))
    else $error("total update for a rejected observation");

  // each unit finishes only while the sequencer waits for it
  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == rwiu_pkg::ST_MUL))
    else $error("multiplier finished out of sequence");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == rwiu_pkg::ST_DIV))
    else $error("divider finished out of sequence");

  a_acc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done |-> (state_q == rwiu_pkg::ST_ACC))
    else $error("accumulator finished out of sequence");

  // the division only runs when the expected advance exceeds the modular one
  a_div_lift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rwiu_pkg::ST_DIV) |-> lift_en_q)
    else $error("ring count computed without a shortfall");
`endif

endmodule

`default_nettype wire

### tb/ring_write_index_unwrapper_tb.sv
`timescale 1ns / 100ps

module ring_write_index_unwrapper_tb;
  import rwiu_pkg::*;

  localparam int unsigned MAX_RING_WORDS  = 65536;
  // random observations after the directed table, about 1900 in all
  localparam int unsigned RANDOM_OBS      = 1880;
  // two long receiver hold-offs so the block fills and stalls its input
  localparam int unsigned HOLD_OFF_CYCLES = 700;
  // slowest quiet stretch is roughly a hold-off, one observation's work and a sender gap
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned SETTLE_CYCLES   = 200;

  // one result as the block reports it
  typedef struct packed {
    logic [TOT_W-1:0] total;
    status_e          status;
  } tally_t;

  typedef enum logic {ROW_WRITE, ROW_OBS} row_kind_e;

  // one row of the directed table: a register write or an observation,
  // the latter with an optional hand-written result
  typedef struct packed {
    row_kind_e        kind;
    reg_idx_e         sel;
    logic [CFG_W-1:0] data;
    logic [IDX_W-1:0] idx;
    logic [FRM_W-1:0] frames;
    logic             typed;
    tally_t           want;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  reg_idx_e             cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [IDX_W-1:0]     write_index_i;
  logic [FRM_W-1:0]     frame_count_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [TOT_W-1:0]     total_words_o;
  logic [STS_W-1:0]     status_o;

  // register copies kept alongside the block
  logic [RING_W-1:0]    ring_len;
  logic [IDX_W-1:0]     start_index;
  logic [FRM_W-1:0]     start_frames;
  logic [FSZ_W-1:0]     frame_words;
  // unwrapping state: running word total and the last accepted observation
  logic [TOT_W-1:0]     word_sum;
  logic [IDX_W-1:0]     prev_index;
  logic [FRM_W-1:0]     prev_frames;

  tally_t               owed_totals[$];
  row_t                 directed_rows[$];
  int unsigned          mismatches   = 0;
  int unsigned          results_seen = 0;
  int unsigned          quiet_cycles = 0;

  ring_write_index_unwrapper #(
    .MAX_RING_WORDS(MAX_RING_WORDS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .write_index_i(write_index_i),
    .frame_count_i(frame_count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .total_words_o(total_words_o),
    .status_o     (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // writes to any of the first three registers start the count afresh
  function automatic void restart_tracking();
    word_sum    = '0;
    prev_index  = start_index;
    prev_frames = start_frames;
  endfunction

  function automatic void apply_write(input reg_idx_e sel, input logic [CFG_W-1:0] data);
    case (sel)
      REG_RING_SIZE: begin
        ring_len = data[RING_W-1:0];
        restart_tracking();
      end
      REG_START_INDEX: begin
        start_index = data[IDX_W-1:0];
        restart_tracking();
      end
      REG_START_FRAMES: begin
        start_frames = data[FRM_W-1:0];
        restart_tracking();
      end
      REG_FRAME_SIZE: begin
        // frame size alone leaves the running state untouched
        frame_words = data[FSZ_W-1:0];
      end
      default: ;
    endcase
  endfunction

  // true when an in-range index would give an ok status
  function automatic bit setting_usable();
    return ring_len >= RING_MIN && ring_len <= MAX_RING_WORDS &&
           start_index < ring_len &&
           (frame_words == 0 || 2 * frame_words < ring_len);
  endfunction

  // works out the result of one observation and advances the state on success
  function automatic void unwrap_observation(input logic [IDX_W-1:0] idx,
                                             input logic [FRM_W-1:0] frames,
                                             output tally_t res);
    longint unsigned ring, fsz, mod_delta, observed, expected, missing;
    longint unsigned rings, lifted, err;
    logic [FRM_W-1:0] fdelta;
    status_e sts;
    ring = ring_len;
    fsz  = frame_words;
    // error precedence: configuration, then index, then frame size
    if (ring_len < RING_MIN || ring_len > MAX_RING_WORDS || start_index >= ring_len)
      sts = STS_CFG_INVALID;
    else if (idx >= ring_len)
      sts = STS_INDEX_RANGE;
    else if (fsz != 0 && fsz * 2 >= ring)
      sts = STS_FRAME_LARGE;
    else
      sts = STS_OK;
    if (sts == STS_OK) begin
      if (idx >= prev_index) mod_delta = idx - prev_index;
      else mod_delta = ring - prev_index + idx;
      observed = mod_delta;
      if (fsz != 0) begin
        fdelta   = frames - prev_frames;
        expected = longint'(fdelta) * fsz;
        if (expected > mod_delta) begin
          // round the shortfall to whole rings, keep it only if close to the frame estimate
          missing = expected - mod_delta;
          rings   = (missing + ring / 2) / ring;
          lifted  = mod_delta + rings * ring;
          err     = (lifted >= expected) ? lifted - expected : expected - lifted;
          if (rings != 0 && err <= fsz) observed = lifted;
        end
      end
      word_sum    = word_sum + observed;
      prev_index  = idx;
      prev_frames = frames;
    end
    res.total  = word_sum;
    res.status = sts;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_write(input reg_idx_e sel, input logic [CFG_W-1:0] data);
    row_t row;
    row        = '0;
    row.kind   = ROW_WRITE;
    row.sel    = sel;
    row.data   = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_obs(input logic [IDX_W-1:0] idx, input logic [FRM_W-1:0] frames);
    row_t row;
    row        = '0;
    row.kind   = ROW_OBS;
    row.idx    = idx;
    row.frames = frames;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked(input logic [IDX_W-1:0] idx,
                                      input logic [FRM_W-1:0] frames,
                                      input logic [TOT_W-1:0] total, input status_e sts);
    row_t row;
    row             = '0;
    row.kind        = ROW_OBS;
    row.idx         = idx;
    row.frames      = frames;
    row.typed       = 1'b1;
    row.want.total  = total;
    row.want.status = sts;
    directed_rows.push_back(row);
  endfunction

  // random bits above the register width must be ignored by the block
  function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] v, input int unsigned w);
    logic [CFG_W-1:0] junk;
    junk = $urandom;
    if ($urandom_range(1, 0) != 0 && w < CFG_W) return v | (junk << w);
    return v;
  endfunction

  // mostly a plausible producer: frames advance and the index moves by about
  // frames * frame size, often by many rings; the rest is noise
  function automatic void make_obs(output logic [IDX_W-1:0] idx,
                                   output logic [FRM_W-1:0] frames);
    longint unsigned ring, fsz, k, advance;
    int unsigned pick;
    ring   = ring_len;
    fsz    = frame_words;
    pick   = $urandom_range(19, 0);
    idx    = $urandom;
    frames = $urandom;
    if (setting_usable() && pick >= 4) begin
      pick = $urandom_range(19, 0);
      if (pick < 8) k = $urandom_range(3, 0);
      else if (pick < 15) k = $urandom_range(64, 4);
      else if (pick < 19) k = $urandom_range(200000, 0);
      else k = $urandom;
      if (fsz == 0) begin
        advance = $urandom_range(3 * ring, 0);
      end else begin
        advance = k * fsz + $urandom_range(fsz, 0);
        if (advance >= fsz / 2) advance = advance - fsz / 2;
      end
      idx    = IDX_W'((prev_index + advance) % ring);
      frames = prev_frames + FRM_W'(k);
    end else if (ring_len >= RING_MIN && ring_len <= MAX_RING_WORDS) begin
      case (pick % 4)
        1: idx = $urandom_range(ring_len - 1, 0);
        2: if (ring_len < MAX_RING_WORDS) idx = $urandom_range(65535, ring_len);
        3: idx = prev_index;
        default: ;
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driving tasks: inputs change on the falling edge, handshakes seen on the rising edge
  // ---------------------------------------------------------------------------

  task automatic write_reg(input reg_idx_e sel, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_write(sel, data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_obs(input logic [IDX_W-1:0] idx, input logic [FRM_W-1:0] frames,
                          input logic typed, input tally_t want);
    tally_t res;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    write_index_i <= idx;
    frame_count_i <= frames;
    do @(posedge clk_i); while (in_stall_o);
    unwrap_observation(idx, frames, res);
    owed_totals.push_back(typed ? want : res);
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n != 0) begin
      @(negedge clk_i);
      in_valid_i    <= 1'b0;
      write_index_i <= $urandom;
      frame_count_i <= $urandom;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // registers may only change once every outstanding result has been taken
  task automatic drain_results();
    if (in_valid_i) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    while (owed_totals.size() != 0) @(posedge clk_i);
  endtask

  // new register setting for a random phase, each register written with some chance
  task automatic pick_setting();
    logic [CFG_W-1:0] v;
    int unsigned choice, max_ok, half;
    if ($urandom_range(9, 0) < 7) begin
      choice = $urandom_range(19, 0);
      if (choice == 0)
        v = ($urandom_range(1, 0) != 0) ? $urandom_range(1, 0)
                                        : $urandom_range(131071, MAX_RING_WORDS + 1);
      else if (choice == 1) v = 2;
      else if (choice == 2) v = 3;
      else if (choice == 3) v = MAX_RING_WORDS;
      else if (choice < 8)  v = 1 << $urandom_range(16, 2);
      else                  v = $urandom_range(MAX_RING_WORDS, 4);
      write_reg(REG_RING_SIZE, with_junk(v, RING_W));
    end
    if ($urandom_range(9, 0) < 7) begin
      if (ring_len >= RING_MIN && ring_len <= MAX_RING_WORDS && $urandom_range(9, 0) != 0)
        v = $urandom_range(ring_len - 1, 0);
      else
        v = $urandom_range(65535, 0);
      write_reg(REG_START_INDEX, with_junk(v, IDX_W));
    end
    if ($urandom_range(9, 0) < 6) begin
      // counts just short of the wrap are worth seeing often
      v = ($urandom_range(3, 0) == 0) ? 32'hFFFF_FFFF - $urandom_range(15, 0) : $urandom;
      write_reg(REG_START_FRAMES, v);
    end
    if ($urandom_range(9, 0) < 7) begin
      max_ok = (ring_len > 2) ? (ring_len - 1) / 2 : 0;
      if (max_ok > 32767) max_ok = 32767;
      half   = (ring_len + 1) / 2;
      choice = $urandom_range(9, 0);
      if (choice < 2 || max_ok == 0) v = 0;
      else if (choice == 2) v = max_ok;
      else if (choice == 3 && half >= 1 && half <= 32767) v = $urandom_range(32767, half);
      else v = $urandom_range(max_ok, 1);
      write_reg(REG_FRAME_SIZE, with_junk(v, FSZ_W));
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall patterns of its own, plus long hold-offs while the sender is busy
  // ---------------------------------------------------------------------------

  initial begin : stall_gen
    int unsigned mode, span, k;
    bit held_early, held_late;
    held_early = 1'b0;
    held_late  = 1'b0;
    forever begin
      if (in_valid_i && ((!held_early && results_seen >= 100) ||
                         (!held_late && results_seen >= 1000))) begin
        if (!held_early) held_early = 1'b1;
        else held_late = 1'b1;
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end else begin
        mode = $urandom_range(3, 0);
        span = $urandom_range(400, 20);
        for (k = 0; k < span; k++) begin
          @(negedge clk_i);
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(9, 0) < 3);
            2: out_stall_i <= ($urandom_range(9, 0) < 8);
            default: out_stall_i <= (k % 4 != 0);
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking against the oldest outstanding expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_check
    tally_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (owed_totals.size() == 0) begin
        $error("unexpected result: total_words %0h status %0d", total_words_o, status_o);
        mismatches++;
      end else begin
        want = owed_totals.pop_front();
        if (total_words_o !== want.total) begin
          $error("total_words: expected %0h, got %0h", want.total, total_words_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without any transfer or register write means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ring_write_index_unwrapper test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    row_t             row;
    logic [IDX_W-1:0] idx;
    logic [FRM_W-1:0] frames;
    int unsigned      random_sent, phase_len, burst_left;
    bit               no_gaps;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_RING_SIZE;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    write_index_i = '0;
    frame_count_i = '0;
    out_stall_i   = 1'b0;

    // register reset values
    ring_len     = RING_RESET;
    start_index  = '0;
    start_frames = '0;
    frame_words  = '0;
    restart_tracking();

    // reset setting: ring of 1024, no frame size
    add_checked(16'd0, 32'd0, 64'd0, STS_OK);
    add_checked(16'd1023, 32'd0, 64'd1023, STS_OK);
    add_checked(16'd1024, 32'd0, 64'd1023, STS_INDEX_RANGE);
    add_checked(16'hFFFF, 32'hFFFF_FFFF, 64'd1023, STS_INDEX_RANGE);
    // index wraps past the ring end
    add_checked(16'd5, 32'd0, 64'd1029, STS_OK);
    // frame size of half the ring is refused
    add_write(REG_FRAME_SIZE, 32'd512);
    add_checked(16'd0, 32'd0, 64'd1029, STS_FRAME_LARGE);
    // lifting: one whole ring missed, frame count wrap, too few words, estimate too far off
    add_write(REG_FRAME_SIZE, 32'd511);
    add_obs(16'd5, 32'd3);
    add_obs(16'd5, 32'd2);
    add_obs(16'd405, 32'd3);
    add_write(REG_FRAME_SIZE, 32'd100);
    add_obs(16'd405, 32'd9);
    // invalid ring sizes restart the count and report a bad setting
    add_write(REG_RING_SIZE, 32'd0);
    add_checked(16'd0, 32'd0, 64'd0, STS_CFG_INVALID);
    add_write(REG_RING_SIZE, 32'd1);
    add_checked(16'd0, 32'd0, 64'd0, STS_CFG_INVALID);
    add_write(REG_RING_SIZE, MAX_RING_WORDS + 1);
    add_checked(16'd0, 32'd0, 64'd0, STS_CFG_INVALID);
    add_write(REG_RING_SIZE, 32'hFFFF_FFFF);
    add_checked(16'd7, 32'd7, 64'd0, STS_CFG_INVALID);
    // largest ring, start registers and frame size at their top values
    add_write(REG_RING_SIZE, MAX_RING_WORDS);
    add_write(REG_START_INDEX, 32'hFFFF);
    add_write(REG_START_FRAMES, 32'hFFFF_FFFF);
    add_write(REG_FRAME_SIZE, 32'h7FFF);
    add_checked(16'hFFFF, 32'hFFFF_FFFF, 64'd0, STS_OK);
    add_obs(16'd0, 32'd0);
    add_obs(16'h8000, 32'h7FFF_FFFF);
    // smallest ring; start index not below it outranks an index out of range
    add_write(REG_RING_SIZE, 32'd2);
    add_write(REG_START_INDEX, 32'd2);
    add_checked(16'd3, 32'd0, 64'd0, STS_CFG_INVALID);
    // index out of range outranks the frame size check
    add_write(REG_START_INDEX, 32'd1);
    add_checked(16'd2, 32'd0, 64'd0, STS_INDEX_RANGE);
    add_checked(16'd0, 32'd0, 64'd0, STS_FRAME_LARGE);
    add_write(REG_FRAME_SIZE, 32'd0);
    add_checked(16'd0, 32'd0, 64'd1, STS_OK);
    add_checked(16'd1, 32'd5, 64'd2, STS_OK);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        write_reg(row.sel, row.data);
      end else begin
        send_obs(row.idx, row.frames, row.typed, row.want);
        pause_sender($urandom_range(3, 0));
      end
    end

    // random phases: new setting, then a batch sent in bursts
    random_sent = 0;
    while (random_sent < RANDOM_OBS) begin
      drain_results();
      pick_setting();
      // settings that reject everything get only a short batch
      phase_len  = setting_usable() ? $urandom_range(120, 20) : $urandom_range(10, 3);
      no_gaps    = ($urandom_range(3, 0) == 0);
      burst_left = $urandom_range(20, 1);
      repeat (phase_len) begin
        make_obs(idx, frames);
        send_obs(idx, frames, 1'b0, '0);
        random_sent++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(20, 1);
          if (!no_gaps) pause_sender($urandom_range(30, 1));
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("ring_write_index_unwrapper test passed");
    else
      $display("ring_write_index_unwrapper test failed");
    $finish;
  end

endmodule

### filelist.f
src/rwiu_pkg.sv
src/rwiu_ser_mul.sv
src/rwiu_ser_div.sv
src/rwiu_ser_acc.sv
src/ring_write_index_unwrapper.sv
tb/ring_write_index_unwrapper_tb.sv
